/* hdl/fbpa_pkg.sv */
// Package for the fixed block pool allocator.
// Field widths, status and opcode codes, FSM states and the ctrl/datapath structs.
// No dependencies.
package fbpa_pkg;

   localparam int ADDR_W      = 48;
   localparam int SIZE_W      = 32;
   localparam int ALIGN_W     = 16;
   localparam int BSIZE_W     = 17;
   localparam int EFF_W       = 18;
   localparam int BYTES_W     = 25;
   localparam int BIU_W       = 9;
   localparam int REQ_DATA_W  = 96;
   localparam int RSP_DATA_W  = 208;
   localparam int RSP_PAD_W   = 5;
   localparam int STATUS_W    = 3;
   localparam int CSR_IDX_W   = 1;

   localparam logic [BSIZE_W-1:0] BSIZE_RESET = 17'd64;
   localparam logic [ADDR_W-1:0]  BASE_RESET  = 48'h0000_0001_0000;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDR  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_ALLOCATED    = 3'd0,
      ST_FREED        = 3'd1,
      ST_TOO_LARGE    = 3'd2,
      ST_EMPTY        = 3'd3,
      ST_OVER_ALIGNED = 3'd4,
      ST_NULL_IGNORED = 3'd5,
      ST_NOT_OWNED    = 3'd6
   } fbpa_status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_PREP,
      S_CHECK,
      S_DIV,
      S_PUSH,
      S_STATS,
      S_OUT
   } fbpa_state_type;

   typedef struct packed {
      logic init_wr;
      logic capture;
      logic prep;
      logic check;
      logic div_step;
      logic push;
      logic stats;
      logic out_load;
   } fbpa_cmd_type;

   typedef struct packed {
      logic init_last;
      logic free_go;
      logic div_last;
      logic out_free;
   } fbpa_stat_type;

endpackage

/* hdl/fixed_block_pool_allocator_unit.sv */
// Top level of the fixed block pool allocator: LIFO free list over NUM_BLOCKS blocks.
// Depends on fbpa_pkg, fbpa_ctrl, fbpa_dp (which holds fbpa_ram).
//
//  channel | direction | handshake              | payload
//  req     | in        | req_tvalid/req_tready  | tuser op, tdata size/align/address
//  rsp     | out       | rsp_tvalid/rsp_tready  | tuser status, tdata address/stats
//  csr     | in        | csr_we                 | csr_index, csr_wdata
//
// Allocate and refused requests pass PREP, CHECK, STATS and OUT from accept to result; a
// free that reaches the one-bit-a-cycle divider also passes DIV and PUSH before STATS.
// After reset the link table init pass writes every entry with req_tready low.
// One request is in work at a time; a finished result waits in the output register
// while the next request is accepted, and rsp_tready low stalls only the handoff.
module fixed_block_pool_allocator_unit #(
   parameter int NUM_BLOCKS = 256,
   parameter int MAX_ALIGN  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_tuser,   // op
   input  logic [fbpa_pkg::REQ_DATA_W-1:0]   req_tdata,   // request_size, request_alignment,
                                                          // free_address
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fbpa_pkg::STATUS_W-1:0]     rsp_tuser,   // status
   output logic [fbpa_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // block_address, allocated_bytes,
                                                          // peak_bytes, blocks_in_use,
                                                          // total_allocs, total_frees, pad
   input  logic                              csr_we,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]       csr_wdata
);
   import fbpa_pkg::*;

   fbpa_cmd_type  cmd;
   fbpa_stat_type stat;

   fbpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fbpa_dp #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .MAX_ALIGN  (MAX_ALIGN)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous request still in work");

   a_init_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("request accepted before link table init");

   a_zero_addr_unless_alloc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_ALLOCATED) |-> (rsp_tdata[ADDR_W-1:0] == '0))
      else $error("nonzero block address on a result that is not an allocation");

   a_single_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("result register overwritten before handoff");

endmodule

/* hdl/fbpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/fbpa_ctrl.sv */
// Sequencer for the block pool allocator: link table init, request flow, result handoff.
// Depends on fbpa_pkg.
module fbpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  fbpa_pkg::fbpa_stat_type stat,
   output fbpa_pkg::fbpa_cmd_type  cmd
);
   import fbpa_pkg::*;

   fbpa_state_type state_ff;
   fbpa_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.init_wr = 1'b1;
            if (stat.init_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.free_go ? S_DIV : S_STATS;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = S_STATS;
         end
         S_STATS: begin
            cmd.stats = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

endmodule

/* hdl/fbpa_dp.sv */
// Datapath for the block pool allocator: config registers, free list, divider, statistics.
// Depends on fbpa_pkg and fbpa_ram.
module fbpa_dp #(
   parameter int NUM_BLOCKS = 256,
   parameter int MAX_ALIGN  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]            csr_wdata,
   input  logic                                   req_tuser,
   input  logic [fbpa_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  fbpa_pkg::fbpa_cmd_type                 cmd,
   output fbpa_pkg::fbpa_stat_type                stat,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [fbpa_pkg::STATUS_W-1:0]          rsp_tuser,
   output logic [fbpa_pkg::RSP_DATA_W-1:0]        rsp_tdata
);
   import fbpa_pkg::*;

   localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
   localparam int SPAN_W = EFF_W + CNT_W;
   localparam int STEP_W = (IDX_W > 1) ? $clog2(IDX_W) : 1;
   localparam logic [EFF_W-1:0] ALIGN_MASK = EFF_W'(MAX_ALIGN - 1);

   // configuration
   logic [BSIZE_W-1:0] bsize_ff;
   logic [ADDR_W-1:0]  base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bsize_ff <= BSIZE_RESET;
         base_ff  <= BASE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BLOCK_SIZE: bsize_ff <= csr_wdata[BSIZE_W-1:0];
            CSR_BASE_ADDR:  base_ff  <= csr_wdata;
            default:        bsize_ff <= bsize_ff;
         endcase
      end
   end

   // effective block size
   logic [EFF_W-1:0] eff_raw;
   logic [EFF_W-1:0] eff_in;

   always_comb begin
      eff_raw = {1'b0, bsize_ff};
      if (eff_raw < EFF_W'(MAX_ALIGN)) begin
         eff_raw = EFF_W'(MAX_ALIGN);
      end
      eff_in = (eff_raw + ALIGN_MASK) & ~ALIGN_MASK;
   end

   // request capture
   logic                op_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [ALIGN_W-1:0]  align_ff;
   logic [ADDR_W-1:0]   faddr_ff;
   logic [EFF_W-1:0]    eff_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_tuser;
         size_ff  <= req_tdata[SIZE_W-1:0];
         align_ff <= req_tdata[SIZE_W+ALIGN_W-1:SIZE_W];
         faddr_ff <= req_tdata[REQ_DATA_W-1:SIZE_W+ALIGN_W];
         eff_ff   <= eff_in;
      end
   end

   // prep: pool span, block offset, free address offset
   logic [SPAN_W-1:0] span_ff;
   logic [SPAN_W-1:0] idxoff_ff;
   logic [ADDR_W:0]   off_ff;
   logic [IDX_W-1:0]  head_ff;

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         span_ff   <= SPAN_W'(eff_ff) * SPAN_W'(NUM_BLOCKS);
         idxoff_ff <= SPAN_W'(head_ff) * SPAN_W'(eff_ff);
         off_ff    <= {1'b0, faddr_ff} - {1'b0, base_ff};
      end
   end

   // free list link table
   logic [IDX_W-1:0]  init_cnt_ff;
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [IDX_W-1:0]  ram_wdata;
   logic [IDX_W-1:0]  ram_rdata;
   logic [IDX_W-1:0]  q_ff;
   logic [SPAN_W-1:0] rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_cnt_ff <= '0;
      end else if (cmd.init_wr) begin
         init_cnt_ff <= init_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = q_ff;
      ram_wdata = head_ff;
      if (cmd.init_wr) begin
         ram_we    = 1'b1;
         ram_waddr = init_cnt_ff;
         ram_wdata = (init_cnt_ff == '0) ? '0 : init_cnt_ff - 1'b1;
      end else if (cmd.push && (rem_ff == '0)) begin
         ram_we = 1'b1;
      end
   end

   fbpa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NUM_BLOCKS)
   ) u_link_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (head_ff),
      .rdata (ram_rdata)
   );

   // check decisions
   logic            under_base;
   logic            in_range;
   logic            alloc_go;
   logic            free_go;
   fbpa_status_type code;
   logic [CNT_W-1:0] free_cnt_ff;
   logic [CNT_W-1:0] peak_ff;
   logic [ADDR_W-1:0] alloc_total_ff;
   logic [CNT_W-1:0] in_use_next;

   always_comb begin
      under_base = off_ff[ADDR_W];
      in_range   = !under_base && (off_ff[ADDR_W-1:0] < ADDR_W'(span_ff));
      alloc_go   = 1'b0;
      free_go    = 1'b0;
      if (op_ff == OP_ALLOC) begin
         if (size_ff > SIZE_W'(eff_ff)) begin
            code = ST_TOO_LARGE;
         end else if (free_cnt_ff == '0) begin
            code = ST_EMPTY;
         end else if (align_ff > ALIGN_W'(MAX_ALIGN)) begin
            code = ST_OVER_ALIGNED;
         end else begin
            code     = ST_ALLOCATED;
            alloc_go = 1'b1;
         end
      end else begin
         if (faddr_ff == '0) begin
            code = ST_NULL_IGNORED;
         end else if (!in_range) begin
            code = ST_NOT_OWNED;
         end else begin
            code    = ST_FREED;
            free_go = 1'b1;
         end
      end
      in_use_next = CNT_W'(NUM_BLOCKS) - (free_cnt_ff - 1'b1);
   end

   // restoring divider state
   logic [STEP_W-1:0] step_ff;
   logic [SPAN_W-1:0] div_d;
   logic              div_ge;

   always_comb begin
      div_d  = SPAN_W'(eff_ff) << step_ff;
      div_ge = rem_ff >= div_d;
   end

   // free list state, status and block address
   fbpa_status_type   status_ff;
   logic [ADDR_W-1:0] addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= IDX_W'(NUM_BLOCKS - 1);
         free_cnt_ff    <= CNT_W'(NUM_BLOCKS);
         peak_ff        <= '0;
         alloc_total_ff <= '0;
      end else if (cmd.check && alloc_go) begin
         head_ff        <= ram_rdata;
         free_cnt_ff    <= free_cnt_ff - 1'b1;
         alloc_total_ff <= alloc_total_ff + 1'b1;
         if (in_use_next > peak_ff) begin
            peak_ff <= in_use_next;
         end
      end else if (cmd.push && (rem_ff == '0)) begin
         head_ff <= q_ff;
         if (free_cnt_ff < CNT_W'(NUM_BLOCKS)) begin
            free_cnt_ff <= free_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         status_ff <= code;
         addr_ff   <= alloc_go ? base_ff + ADDR_W'(idxoff_ff) : '0;
         rem_ff    <= off_ff[SPAN_W-1:0];
         q_ff      <= '0;
         step_ff   <= STEP_W'(IDX_W - 1);
      end else if (cmd.div_step) begin
         if (div_ge) begin
            rem_ff <= rem_ff - div_d;
         end
         q_ff    <= (q_ff << 1) | IDX_W'(div_ge);
         step_ff <= step_ff - 1'b1;
      end else if (cmd.push && (rem_ff != '0)) begin
         status_ff <= ST_NOT_OWNED;
      end
   end

   // statistics snapshot
   logic [CNT_W-1:0]   in_use_cur;
   logic [SPAN_W-1:0]  prod_alloc;
   logic [SPAN_W-1:0]  prod_peak;
   logic [BYTES_W-1:0] abytes_ff;
   logic [BYTES_W-1:0] pbytes_ff;
   logic [BIU_W-1:0]   biu_ff;
   logic [ADDR_W-1:0]  tfree_ff;

   always_comb begin
      in_use_cur = CNT_W'(NUM_BLOCKS) - free_cnt_ff;
      prod_alloc = SPAN_W'(in_use_cur) * SPAN_W'(eff_ff);
      prod_peak  = SPAN_W'(peak_ff) * SPAN_W'(eff_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.stats) begin
         abytes_ff <= BYTES_W'(prod_alloc);
         pbytes_ff <= BYTES_W'(prod_peak);
         biu_ff    <= BIU_W'(in_use_cur);
         tfree_ff  <= alloc_total_ff - ADDR_W'(in_use_cur);
      end
   end

   // result register
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= {{RSP_PAD_W{1'b0}}, tfree_ff, alloc_total_ff, biu_ff,
                           pbytes_ff, abytes_ff, addr_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      stat.init_last = (init_cnt_ff == IDX_W'(NUM_BLOCKS - 1));
      stat.free_go   = free_go;
      stat.div_last  = (step_ff == '0);
      stat.out_free  = !rsp_valid_ff || rsp_tready;
   end

endmodule
